// ===== src/prc_pkg.sv =====
package prc_pkg;

  localparam int XW = 36;
  localparam int ZW = 27;
  localparam int TW = 5;

  localparam logic [15:0]          GAIN_Q16     = 16'd39797;
  localparam logic signed [16:0]   HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0]   FULL_TURN    = 17'sd46080;
  localparam logic signed [16:0]   QUARTER_TURN = 17'sd11520;
  localparam logic signed [ZW-1:0] Z_HALF_TURN  = 27'sd11796480;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] angle_in;
    logic [14:0]        radius_in;
    logic signed [15:0] real_in;
    logic signed [15:0] imag_in;
  } prc_in_t;

  typedef struct packed {
    logic signed [15:0] real_out;
    logic signed [15:0] imag_out;
    logic [15:0]        magnitude_out;
    logic signed [15:0] angle_out;
  } prc_out_t;

  typedef struct packed {
    logic                 mode;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } prc_vec_t;

  // atan(2^-k) in degrees, Q16
  function automatic logic [22:0] atan_q16(input logic [TW-1:0] k);
    logic [22:0] v;
    case (k)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/prc_pre.sv =====
module prc_pre
  import prc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  prc_in_t  in_item,
  output logic     vld,
  output prc_vec_t vec
);

  logic signed [16:0]   a_ext;
  logic signed [16:0]   a_wrap;
  logic signed [16:0]   a_quad;
  logic                 quad_neg;
  logic [30:0]          r_prod;
  logic signed [XW-1:0] r_x;
  logic signed [XW-1:0] re_x;
  logic signed [XW-1:0] im_y;
  prc_vec_t             vec_next;

  always_comb begin
    a_ext = 17'(in_item.angle_in);
    if (a_ext > HALF_TURN) begin
      a_wrap = a_ext - FULL_TURN;
    end else if (a_ext < -HALF_TURN) begin
      a_wrap = a_ext + FULL_TURN;
    end else begin
      a_wrap = a_ext;
    end

    quad_neg = 1'b0;
    a_quad   = a_wrap;
    if (a_wrap > QUARTER_TURN) begin
      quad_neg = 1'b1;
      a_quad   = a_wrap - HALF_TURN;
    end else if (a_wrap < -QUARTER_TURN) begin
      quad_neg = 1'b1;
      a_quad   = a_wrap + HALF_TURN;
    end

    r_prod = 31'(in_item.radius_in) * 31'(GAIN_Q16);
    r_x    = XW'(signed'({1'b0, r_prod}));
    re_x   = XW'(in_item.real_in) <<< 16;
    im_y   = XW'(in_item.imag_in) <<< 16;

    vec_next.mode = in_item.mode;
    if (!in_item.mode) begin
      vec_next.x = quad_neg ? -r_x : r_x;
      vec_next.y = '0;
      vec_next.z = ZW'(a_quad) <<< 9;
    end else if (in_item.real_in < 0) begin
      vec_next.x = -re_x;
      vec_next.y = -im_y;
      vec_next.z = (in_item.imag_in >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
    end else begin
      vec_next.x = re_x;
      vec_next.y = im_y;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec <= vec_next;
    end
  end

endmodule

// ===== src/prc_stage.sv =====
module prc_stage
  import prc_pkg::*;
#(
  parameter int STEP = 0
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     vld_in,
  input  prc_vec_t vec_in,
  output logic     vld,
  output prc_vec_t vec
);

  localparam logic signed [ZW-1:0] ATAN = signed'({4'b0, atan_q16(TW'(STEP))});

  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [ZW-1:0] z_in;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic                 ccw;
  prc_vec_t             vec_next;

  always_comb begin
    x_in = vec_in.x;
    y_in = vec_in.y;
    z_in = vec_in.z;
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    ccw  = vec_in.mode ? (y_in < 0) : (z_in >= 0);

    vec_next.mode = vec_in.mode;
    if (ccw) begin
      vec_next.x = x_in - ys;
      vec_next.y = y_in + xs;
      vec_next.z = z_in - ATAN;
    end else begin
      vec_next.x = x_in + ys;
      vec_next.y = y_in - xs;
      vec_next.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec <= vec_next;
    end
  end

endmodule

// ===== src/prc_post.sv =====
module prc_post
  import prc_pkg::*;
#(
  parameter int DATA_WIDTH = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     vld_in,
  input  prc_vec_t vec_in,
  output logic     vld,
  output prc_out_t res
);

  localparam logic signed [39:0] SMAX    = 40'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [39:0] SMIN    = -SMAX - 40'sd1;
  localparam logic signed [39:0] UMAX    = 40'((64'sd1 <<< DATA_WIDTH) - 64'sd1);
  localparam logic signed [39:0] ANG_MAX = 40'sd23040;

  function automatic logic signed [39:0] sat(input logic signed [39:0] v,
                                             input logic signed [39:0] lo,
                                             input logic signed [39:0] hi);
    logic signed [39:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [ZW-1:0] z_in;
  logic signed [19:0]   rx_next;
  logic signed [19:0]   ry_next;
  logic signed [52:0]   prod_next;
  logic signed [17:0]   za_next;

  logic                 p_vld;
  logic                 p_mode;
  logic signed [19:0]   p_rx;
  logic signed [19:0]   p_ry;
  logic signed [52:0]   p_prod;
  logic signed [17:0]   p_za;

  logic signed [20:0]   mag;
  prc_out_t             res_next;

  always_comb begin
    x_in      = vec_in.x;
    y_in      = vec_in.y;
    z_in      = vec_in.z;
    rx_next   = 20'((x_in + 36'sd32768) >>> 16);
    ry_next   = 20'((y_in + 36'sd32768) >>> 16);
    prod_next = 53'(x_in) * 53'sd39797;
    za_next   = 18'((z_in + 27'sd256) >>> 9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      vld   <= 1'b0;
    end else if (en) begin
      p_vld <= vld_in;
      vld   <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mode <= vec_in.mode;
      p_rx   <= rx_next;
      p_ry   <= ry_next;
      p_prod <= prod_next;
      p_za   <= za_next;
    end
  end

  always_comb begin
    mag = 21'((p_prod + 53'sd2147483648) >>> 32);
    if (p_mode) begin
      res_next.real_out      = '0;
      res_next.imag_out      = '0;
      res_next.magnitude_out = 16'(sat(40'(mag), 40'sd0, UMAX));
      res_next.angle_out     = 16'(sat(40'(p_za), -ANG_MAX, ANG_MAX));
    end else begin
      res_next.real_out      = 16'(sat(40'(p_rx), SMIN, SMAX));
      res_next.imag_out      = 16'(sat(40'(p_ry), SMIN, SMAX));
      res_next.magnitude_out = '0;
      res_next.angle_out     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== src/polar_rectangular_converter_top.sv =====
// Polar/rectangular converter on a pipelined CORDIC. Each transfer carries a mode bit: 0 rotates
// (radius_in, 0) by angle_in (degrees x128) to give real_out/imag_out, 1 vectors
// (real_in, imag_in) to give magnitude_out and a four-quadrant angle_out (degrees x128);
// fields of the other mode read as zero. One item is taken every clock cycle while in_stall is low;
// the pipeline holds one preparation stage, one register per CORDIC iteration, two for gain and
// rounding, and one output register. A two-entry output register and skid buffer keep input
// acceptance going while a result waits; in_stall rises only when both are full.
module polar_rectangular_converter_top
  import prc_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int DATA_WIDTH   = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  prc_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output prc_out_t out_item
);

  logic                  en;
  logic [CORDIC_STEPS:0] cv;
  prc_vec_t              cvec [CORDIC_STEPS+1];
  logic                  post_vld;
  prc_out_t              post_res;
  logic                  skid_valid;
  prc_out_t              skid_item;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  prc_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .vld      (cv[0]),
    .vec      (cvec[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    prc_stage #(.STEP(g)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vld_in (cv[g]),
      .vec_in (cvec[g]),
      .vld    (cv[g+1]),
      .vec    (cvec[g+1])
    );
  end

  prc_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vld_in (cv[CORDIC_STEPS]),
    .vec_in (cvec[CORDIC_STEPS]),
    .vld    (post_vld),
    .res    (post_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= post_vld;
      end
    end else if (post_vld && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_item <= skid_valid ? skid_item : post_res;
    end else if (!skid_valid) begin
      skid_item <= post_res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer holds a transfer while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid buffer filled without a stalled output");

  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.magnitude_out != 16'd0) |->
      (out_item.real_out == 16'sd0 && out_item.imag_out == 16'sd0))
    else $error("rectangular fields set alongside a magnitude");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.angle_out <= 16'sd23040 && out_item.angle_out >= -16'sd23040))
    else $error("angle_out beyond a half turn");
`endif

endmodule
